/* rtl/fjb_pkg.sv */
// fjb_pkg: types and constants shared by the frame jitter buffer playout block
// depends on nothing
package fjb_pkg;

    localparam int FRAME_W = 32;
    localparam int SLOT_W  = 6;
    localparam int THR_W   = 6;

    localparam logic [THR_W-1:0] THR_RESET = 6'd24;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_FLUSH = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        STS_PLAYED  = 3'd0,
        STS_STARTED = 3'd1,
        STS_EMPTY   = 3'd2,
        STS_WAITING = 3'd3,
        STS_GAP     = 3'd4,
        STS_PUSHED  = 3'd5,
        STS_DROPPED = 3'd6,
        STS_FLUSHED = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCUR,
        ST_GHEAD,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FRAME_W-1:0] frame_number;
    } t_item;

    typedef struct packed {
        logic              play_valid;
        logic [SLOT_W-1:0] slot_index;
        t_status           status;
        logic              skipped;
    } t_result;

endpackage

/* rtl/fjb_ram.sv */
// fjb_ram: generic single write port, single read port ram with registered read
// depends on nothing
module fjb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/frame_jitter_buffer_playout.sv */
// frame_jitter_buffer_playout: ring of frame numbers with push, pull and flush
// depends on fjb_pkg and fjb_ram
//
//   channel   handshake              payload
//   command   start / busy           i_item   (operation, frame_number)
//   result    o_strobe, one cycle    o_result (play_valid, slot_index, status, skipped)
//   config    i_cfg_we               i_cfg_wdata (prebuffer threshold)
//
// push, flush, and a pull that needs no store read finish in ST_IDLE; the result
// shows on the following cycle.
// a pull while playing with a sequence check passes ST_GCUR and ST_GHEAD (two ram reads).
// a pull over the threshold while not playing scans the queue in ST_SCAN, one ram read
// per queued frame, then ST_FIN starts playout or waits.
// synchronous active-low reset clears the indexes and flags; the ram needs no clear.
// results cannot be held off by the receiver.
module frame_jitter_buffer_playout #(
    parameter int RING_DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  fjb_pkg::t_item          i_item,
    input  logic                    i_cfg_we,
    input  logic [fjb_pkg::THR_W-1:0] i_cfg_wdata,
    output logic                    o_strobe,
    output fjb_pkg::t_result        o_result
);
    import fjb_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int QW = IW + 1;
    localparam int CW = (QW > THR_W) ? QW : THR_W;

    t_state             r_state, n_state;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_tail, n_tail;
    logic [IW-1:0]      r_cur, n_cur;
    logic               r_cur_valid, n_cur_valid;
    logic               r_wipe, n_wipe;
    logic [THR_W-1:0]   r_thr;
    logic [IW-1:0]      r_idx, n_idx;
    logic [FRAME_W-1:0] r_prev, n_prev;
    logic               r_first, n_first;
    logic               r_skip, n_skip;
    logic               r_stb, n_stb;
    t_result            r_out, n_out;

    logic               ram_we;
    logic [IW-1:0]      ram_raddr;
    logic [FRAME_W-1:0] ram_rdata;

    logic [IW-1:0]      h_eff;
    logic               cv_eff;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
        if (i == IW'(RING_DEPTH - 1)) begin
            return '0;
        end
        return i + IW'(1);
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
        if (i == '0) begin
            return IW'(RING_DEPTH - 1);
        end
        return i - IW'(1);
    endfunction

    function automatic logic over_thr(input logic [IW-1:0] h, input logic [IW-1:0] t,
                                      input logic [THR_W-1:0] thr);
        logic [QW-1:0] q;
        q = {1'b0, t} - {1'b0, h};
        if (t < h) begin
            q = q + QW'(RING_DEPTH);
        end
        return CW'(q) > CW'(thr);
    endfunction

    function automatic t_result mk(input logic v, input logic [IW-1:0] slot,
                                   input t_status s, input logic sk);
        t_result r;
        r.play_valid = v;
        r.slot_index = SLOT_W'(slot);
        r.status     = s;
        r.skipped    = sk;
        return r;
    endfunction

    fjb_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(RING_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_tail),
        .i_wdata(i_item.frame_number),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign h_eff  = r_wipe ? r_tail : r_head;
    assign cv_eff = r_cur_valid & ~r_wipe;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_wipe      = r_wipe;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_first     = r_first;
        n_skip      = r_skip;
        n_stb       = 1'b0;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_raddr   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_item.operation)
                        OP_PUSH: begin
                            n_stb = 1'b1;
                            if (ring_next(r_tail) == r_head) begin
                                n_out = mk(1'b0, '0, STS_DROPPED, 1'b0);
                            end else begin
                                ram_we = 1'b1;
                                n_tail = ring_next(r_tail);
                                n_out  = mk(1'b0, r_tail, STS_PUSHED, 1'b0);
                            end
                        end
                        OP_FLUSH: begin
                            n_stb  = 1'b1;
                            n_wipe = 1'b1;
                            n_head = ring_prev(r_tail);
                            n_out  = mk(1'b0, '0, STS_FLUSHED, 1'b0);
                        end
                        OP_PULL: begin
                            n_wipe      = 1'b0;
                            n_head      = h_eff;
                            n_cur_valid = cv_eff;
                            if (h_eff == r_tail) begin
                                n_cur_valid = 1'b0;
                                n_stb       = 1'b1;
                                n_out       = mk(1'b0, '0, STS_EMPTY, 1'b0);
                            end else if (!cv_eff) begin
                                if (over_thr(h_eff, r_tail, r_thr)) begin
                                    ram_raddr = h_eff;
                                    n_idx     = h_eff;
                                    n_first   = 1'b1;
                                    n_skip    = 1'b0;
                                    n_state   = ST_SCAN;
                                end else begin
                                    n_stb = 1'b1;
                                    n_out = mk(1'b0, '0, STS_WAITING, 1'b0);
                                end
                            end else if (r_cur == h_eff) begin
                                n_cur  = h_eff;
                                n_head = ring_next(h_eff);
                                n_stb  = 1'b1;
                                n_out  = mk(1'b1, h_eff, STS_PLAYED, 1'b0);
                            end else begin
                                ram_raddr = r_cur;
                                n_state   = ST_GCUR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_GCUR: begin
                n_prev    = ram_rdata;
                ram_raddr = r_head;
                n_state   = ST_GHEAD;
            end
            ST_GHEAD: begin
                n_state = ST_IDLE;
                n_stb   = 1'b1;
                if (r_prev + FRAME_W'(1) != ram_rdata) begin
                    n_cur_valid = 1'b0;
                    n_out       = mk(1'b0, '0, STS_GAP, 1'b0);
                end else begin
                    n_cur  = r_head;
                    n_head = ring_next(r_head);
                    n_out  = mk(1'b1, r_head, STS_PLAYED, 1'b0);
                end
            end
            ST_SCAN: begin
                n_prev  = ram_rdata;
                n_first = 1'b0;
                if (!r_first && (r_prev + FRAME_W'(1) != ram_rdata)) begin
                    n_head = r_idx;
                    n_skip = 1'b1;
                end
                if (ring_next(r_idx) == r_tail) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx     = ring_next(r_idx);
                    ram_raddr = ring_next(r_idx);
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
                n_stb   = 1'b1;
                if (over_thr(r_head, r_tail, r_thr)) begin
                    n_cur       = r_head;
                    n_cur_valid = 1'b1;
                    n_head      = ring_next(r_head);
                    n_out       = mk(1'b1, r_head, STS_STARTED, r_skip);
                end else begin
                    n_out = mk(1'b0, '0, STS_WAITING, r_skip);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_wipe      <= 1'b0;
            r_thr       <= THR_RESET;
            r_stb       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_wipe      <= n_wipe;
            r_stb       <= n_stb;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_prev  <= n_prev;
        r_first <= n_first;
        r_skip  <= n_skip;
        r_out   <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_stb;
    assign o_result = r_out;

endmodule

/* rtl/fjb_checker.sv */
// fjb_checker: port-level assertions for frame_jitter_buffer_playout, and its bind
// depends on fjb_pkg
module fjb_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input fjb_pkg::t_item   i_item,
    input logic             o_strobe,
    input fjb_pkg::t_result o_result
);
    import fjb_pkg::*;

    // push and flush beats answer on the next cycle
    a_push_flush_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.operation == OP_PUSH || i_item.operation == OP_FLUSH))
        |=> o_strobe && (o_result.status == STS_PUSHED || o_result.status == STS_DROPPED
                         || o_result.status == STS_FLUSHED))
        else $error("push or flush gave no result");

    // a result leaves the block idle for the next beat
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

    // play_valid only with played or started
    a_play_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.play_valid ==
                      (o_result.status == STS_PLAYED || o_result.status == STS_STARTED)))
        else $error("play_valid disagrees with status");

    // skip flag only on a pull that ran the start scan
    a_skip_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.skipped)
        |-> (o_result.status == STS_STARTED || o_result.status == STS_WAITING))
        else $error("skipped set on wrong status");

endmodule

bind frame_jitter_buffer_playout fjb_checker u_fjb_checker (.*);

/* bench/frame_jitter_buffer_playout_tb.sv */
// frame_jitter_buffer_playout_tb: self-checking bench for the playout jitter buffer
// drives push, pull, flush and reserved beats, predicts each result and scores the strobed output
// depends on fjb_pkg and the frame_jitter_buffer_playout rtl
`timescale 1ns / 100ps

module frame_jitter_buffer_playout_tb;
    import fjb_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int LATENCY = RING_DEPTH + 8;
    localparam int ITEM_TARGET = 700;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_item               i_item = '0;
    logic                i_cfg_we = 1'b0;
    logic [THR_W-1:0]    i_cfg_wdata = '0;
    logic                o_strobe;
    t_result             o_result;

    // predicted buffer state
    logic [FRAME_W-1:0]  ring_frames [RING_DEPTH];
    logic [SLOT_W-1:0]   rd_head = '0;
    logic [SLOT_W-1:0]   wr_tail = '0;
    logic [SLOT_W-1:0]   last_slot = '0;
    logic                playing = 1'b0;
    logic                wipe_armed = 1'b0;
    logic [THR_W-1:0]    threshold = THR_RESET;

    t_result             awaited_beats [$];
    int                  errors = 0;
    int                  beats_sent = 0;
    logic                burst_mode = 1'b0;
    logic [FRAME_W-1:0]  next_frame = '0;

    frame_jitter_buffer_playout #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(3_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [SLOT_W-1:0] frames_queued();
        return wr_tail - rd_head;
    endfunction

    function automatic bit predict_playout(input t_item it, output t_result r);
        logic [FRAME_W-1:0] prev;
        logic [SLOT_W-1:0]  i;
        r = '0;
        case (it.operation)
            OP_PUSH: begin
                if (wr_tail + 6'd1 == rd_head) begin
                    r.status = STS_DROPPED;
                end else begin
                    ring_frames[wr_tail] = it.frame_number;
                    r.slot_index = wr_tail;
                    r.status = STS_PUSHED;
                    wr_tail = wr_tail + 6'd1;
                end
                return 1'b1;
            end
            OP_FLUSH: begin
                wipe_armed = 1'b1;
                rd_head = wr_tail - 6'd1;
                r.status = STS_FLUSHED;
                return 1'b1;
            end
            OP_PULL: begin
                if (wipe_armed) begin
                    wipe_armed = 1'b0;
                    rd_head = wr_tail;
                    playing = 1'b0;
                end
                if (rd_head == wr_tail) begin
                    playing = 1'b0;
                    r.status = STS_EMPTY;
                    return 1'b1;
                end
                if (!playing) begin
                    if (frames_queued() > threshold) begin
                        // move head to the last break in sequence
                        prev = ring_frames[rd_head] - 32'd1;
                        for (i = rd_head; i != wr_tail; i = i + 6'd1) begin
                            if (prev + 32'd1 != ring_frames[i]) begin
                                rd_head = i;
                                r.skipped = 1'b1;
                            end
                            prev = ring_frames[i];
                        end
                    end
                    if (frames_queued() <= threshold) begin
                        r.status = STS_WAITING;
                        return 1'b1;
                    end
                    playing = 1'b1;
                    r.status = STS_STARTED;
                end else begin
                    if (last_slot != rd_head &&
                        ring_frames[last_slot] + 32'd1 != ring_frames[rd_head]) begin
                        playing = 1'b0;
                        r.status = STS_GAP;
                        return 1'b1;
                    end
                    r.status = STS_PLAYED;
                end
                r.play_valid = 1'b1;
                r.slot_index = rd_head;
                last_slot = rd_head;
                rd_head = rd_head + 6'd1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : score_results
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (awaited_beats.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %p", $time, o_result);
            end else begin
                want = awaited_beats.pop_front();
                compare_field("play_valid", 32'(want.play_valid), 32'(o_result.play_valid));
                compare_field("slot_index", 32'(want.slot_index), 32'(o_result.slot_index));
                compare_field("status", 32'(want.status), 32'(o_result.status));
                compare_field("skipped", 32'(want.skipped), 32'(o_result.skipped));
            end
        end
    end

    task automatic send_beat(input logic [1:0] op, input logic [FRAME_W-1:0] frame);
        t_item   it;
        t_result r;
        int      gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        it.operation = op;
        it.frame_number = frame;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (predict_playout(it, r)) begin
            awaited_beats.push_back(r);
        end
        if (op != OP_RESERVED) begin
            beats_sent++;
        end
    endtask

    task automatic push_next();
        send_beat(OP_PUSH, next_frame);
        next_frame = next_frame + 32'd1;
    endtask

    task automatic wait_results_drained();
        if (start) begin
            start <= 1'b0;
        end
        while (awaited_beats.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        threshold = value;
    endtask

    // reset threshold: 24 queued waits, 25 starts
    task automatic test_default_threshold();
        send_beat(OP_PULL, $urandom);
        send_beat(OP_RESERVED, $urandom);
        next_frame = $urandom;
        repeat (24) push_next();
        send_beat(OP_PULL, $urandom);
        push_next();
        send_beat(OP_PULL, $urandom);
        send_beat(OP_FLUSH, $urandom);
        send_beat(OP_PULL, $urandom);
    endtask

    // wrap of frame numbers, start scan skip, gap, flush with a push that the next pull discards
    task automatic test_sequence_cases();
        wait_results_drained();
        set_threshold(6'd1);
        send_beat(OP_PULL, $urandom);
        next_frame = 32'hFFFF_FFFE;
        push_next();
        push_next();
        send_beat(OP_PULL, $urandom);
        push_next();
        repeat (3) send_beat(OP_PULL, $urandom);
        next_frame = 32'd5;
        push_next();
        next_frame = 32'd9;
        push_next();
        push_next();
        send_beat(OP_PULL, $urandom);
        next_frame = 32'd20;
        push_next();
        repeat (3) send_beat(OP_PULL, $urandom);
        send_beat(OP_FLUSH, $urandom);
        push_next();
        send_beat(OP_PULL, $urandom);
    endtask

    // full ring at threshold 62, longest start scan
    task automatic test_full_ring();
        wait_results_drained();
        set_threshold(6'd62);
        next_frame = $urandom;
        burst_mode = 1'b1;
        repeat (RING_DEPTH) push_next();
        burst_mode = 1'b0;
        repeat (2) send_beat(OP_PULL, $urandom);
        send_beat(OP_FLUSH, $urandom);
        send_beat(OP_PULL, $urandom);
    endtask

    task automatic test_random_streams();
        int phase;
        int roll;
        int push_bias;
        logic [THR_W-1:0] thr;
        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            wait_results_drained();
            case ($urandom_range(0, 9))
                0: thr = 6'd62;
                1: thr = 6'($urandom_range(0, 62));
                default: thr = 6'($urandom_range(0, 6));
            endcase
            if (phase == 0) begin
                thr = 6'd0;
            end
            set_threshold(thr);
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                next_frame = 32'hFFFF_FFFF - $urandom_range(0, 40);
            end else begin
                next_frame = $urandom;
            end
            push_bias = $urandom_range(45, 65);
            repeat ($urandom_range(30, 80)) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    send_beat(OP_FLUSH, $urandom);
                end else if (roll < 5) begin
                    send_beat(OP_RESERVED, $urandom);
                end else if (roll < 8) begin
                    send_beat(OP_PUSH, $urandom);
                end else if (roll < 11) begin
                    next_frame = next_frame + $urandom_range(2, 4);
                    push_next();
                end else if (roll < push_bias) begin
                    push_next();
                end else begin
                    send_beat(OP_PULL, $urandom);
                end
                if ($urandom_range(0, 49) == 0) begin
                    wait_results_drained();
                end
            end
            phase++;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_threshold();
        test_sequence_cases();
        test_full_ring();
        test_random_streams();
        wait_results_drained();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/fjb_pkg.sv
rtl/fjb_ram.sv
rtl/frame_jitter_buffer_playout.sv
rtl/fjb_checker.sv
bench/frame_jitter_buffer_playout_tb.sv
